// File: rtl/mbfr_pkg.sv
// shared constants, codes and word types of the msb-first bit field reader
package mbfr_pkg;

   // bit buffer geometry
   localparam int BUF_BITS  = 64;
   localparam int CNT_W     = $clog2(BUF_BITS + 1);

   // word field widths
   localparam int BYTE_W    = 8;
   localparam int NBITS_W   = 6;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int BB_W      = 7;

   // widest field a get may take
   localparam int MAX_FIELD = 32;
   localparam int SIDX_W    = $clog2(MAX_FIELD);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_GET  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [BYTE_W-1:0]     stream_byte;
      logic [NBITS_W-1:0]    field_bits;
      logic                  sign_extend;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]    field_value;
      status_type            status;
      logic [BB_W-1:0]       bits_buffered;
   } rsp_item_type;

   // handshake between the input register and the processing stage
   typedef struct packed {
      logic item_valid;
      logic advance;
   } stage_ctl_type;

endpackage

// File: rtl/mbfr_req_if.sv
// request channel: push and get words into the reader
interface mbfr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [mbfr_pkg::BYTE_W-1:0]   stream_byte;
   logic [mbfr_pkg::NBITS_W-1:0]  field_bits;
   logic                          sign_extend;

   modport source (output valid, output opcode, output stream_byte,
                   output field_bits, output sign_extend, input ready);
   modport sink   (input valid, input opcode, input stream_byte,
                   input field_bits, input sign_extend, output ready);
endinterface

// File: rtl/mbfr_rsp_if.sv
// response channel: one result word per request word
interface mbfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mbfr_pkg::VALUE_W-1:0]   field_value;
   logic [mbfr_pkg::STATUS_W-1:0]  status;
   logic [mbfr_pkg::BB_W-1:0]      bits_buffered;

   modport source (output valid, output field_value, output status,
                   output bits_buffered, input ready);
   modport sink   (input valid, input field_value, input status,
                   input bits_buffered, output ready);
endinterface

// File: rtl/msb_first_bit_field_reader.sv
// top level: msb-first bit field reader with input and result registers
//
//   channel   dir   handshake        word
//   req_chan  in    valid / ready    opcode, stream_byte, field_bits, sign_extend
//   rsp_chan  out   valid / ready    field_value, status, bits_buffered
//
// one word per cycle while rsp_chan is ready; request -> input reg -> result reg
// the barrel shift over the 64-bit buffer sits between input and result registers
// reset clears the buffer, the bit count and both valid flags
// a stalled result holds in its register while one more request waits behind it
module msb_first_bit_field_reader (
   input  logic     clock,
   input  logic     reset,
   mbfr_req_if.sink req_chan,
   mbfr_rsp_if.source rsp_chan
);
   import mbfr_pkg::*;

   stage_ctl_type ctl;
   req_item_type  item;
   rsp_item_type  result;

   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;

   // held word moves on when the result register is free or draining
   assign ctl.advance = ctl.item_valid && (!out_valid_ff || rsp_chan.ready);

   mbfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (ctl.advance),
      .item_valid (ctl.item_valid),
      .item       (item)
   );

   mbfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (item),
      .result (result)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (ctl.advance) begin
         out_valid_in = 1'b1;
         out_item_in  = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.field_value   = out_item_ff.field_value;
   assign rsp_chan.status        = out_item_ff.status;
   assign rsp_chan.bits_buffered = out_item_ff.bits_buffered;

   // a held word never moves into a full, stalled result register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !ctl.advance)
      else $error("result overwritten while stalled");

   // every processed word shows up as a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> out_valid_ff)
      else $error("processed word produced no result");

   // failed words carry a zero field value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.status != ST_OK |-> out_item_ff.field_value == '0)
      else $error("error result with non-zero value");

endmodule

// File: rtl/mbfr_in_reg.sv
// input register that holds one request word ahead of processing
module mbfr_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   mbfr_req_if.sink               req_chan,
   input  logic                   advance,
   output logic                   item_valid,
   output mbfr_pkg::req_item_type item
);
   import mbfr_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   // free when empty or when the held word moves on this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   // next state of the register
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in            = 1'b1;
         item_in.opcode      = opcode_type'(req_chan.opcode);
         item_in.stream_byte = req_chan.stream_byte;
         item_in.field_bits  = req_chan.field_bits;
         item_in.sign_extend = req_chan.sign_extend;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/mbfr_core.sv
// bit buffer state and the single-pass push / get datapath
module mbfr_core (
   input  logic                   clock,
   input  logic                   reset,
   input  mbfr_pkg::stage_ctl_type ctl,
   input  mbfr_pkg::req_item_type item,
   output mbfr_pkg::rsp_item_type result
);
   import mbfr_pkg::*;

   // oldest bit sits at the top of the buffer
   logic [BUF_BITS-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [NBITS_W-1:0]  nbits;
   logic [CNT_W:0]      push_total;
   logic [BUF_BITS-1:0] push_bits;
   logic [VALUE_W-1:0]  top_bits;
   logic [VALUE_W-1:0]  raw_value;
   logic [VALUE_W-1:0]  ext_mask;
   logic [SIDX_W-1:0]   sign_idx;
   logic                sign_set;
   logic [VALUE_W-1:0]  value;
   status_type          status;

   // clamp width, extract field from the top of the buffer
   always_comb begin
      nbits      = (item.field_bits > NBITS_W'(MAX_FIELD)) ?
                   NBITS_W'(MAX_FIELD) : item.field_bits;
      push_total = {1'b0, count_ff} + (CNT_W+1)'(BYTE_W);
      push_bits  = {item.stream_byte, {(BUF_BITS-BYTE_W){1'b0}}} >> count_ff;
      top_bits   = buf_ff[BUF_BITS-1 -: VALUE_W];
      raw_value  = top_bits >> (NBITS_W'(VALUE_W) - nbits);
      ext_mask   = {VALUE_W{1'b1}} << nbits;
      sign_idx   = SIDX_W'(nbits - NBITS_W'(1));
      sign_set   = item.sign_extend && (nbits != '0) && raw_value[sign_idx];
   end

   // result and next state for the held word
   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      value    = '0;
      status   = ST_OK;
      case (item.opcode)
         OP_PUSH: begin
            if (push_total > (CNT_W+1)'(BUF_BITS)) begin
               status = ST_FULL;
            end else begin
               buf_in   = buf_ff | push_bits;
               count_in = push_total[CNT_W-1:0];
            end
         end
         OP_GET: begin
            if (CNT_W'(nbits) > count_ff) begin
               status = ST_SHORT;
            end else begin
               value    = sign_set ? (raw_value | ext_mask) : raw_value;
               buf_in   = buf_ff << nbits;
               count_in = count_ff - CNT_W'(nbits);
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!ctl.advance) begin
         buf_in   = buf_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         count_ff <= '0;
      end else begin
         buf_ff   <= buf_in;
         count_ff <= count_in;
      end
   end

   assign result.field_value   = value;
   assign result.status        = status;
   assign result.bits_buffered = BB_W'(count_in);

   // count never passes the buffer size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUF_BITS))
      else $error("bit count beyond buffer size");

   // bits past the valid count stay clear
   a_tail_clear: assert property (@(posedge clock) disable iff (reset)
      (buf_ff << count_ff) == '0)
      else $error("stale bits below the valid region");

   // an accepted push grows the count by one byte
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && item.opcode == OP_PUSH && status == ST_OK
      |=> count_ff == $past(count_ff) + CNT_W'(BYTE_W))
      else $error("push did not add one byte");

   // a rejected word leaves the state alone
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && status != ST_OK
      |=> $stable(count_ff) && $stable(buf_ff))
      else $error("rejected word changed the buffer");

endmodule
